>>> hdl/ldrd_pkg.sv
package ldrd_pkg;

  // Frame and field limits.
  localparam int MAX_MSG   = 4096;
  localparam int LEN_W     = 13;
  localparam int IDX_W     = 12;
  localparam int HDR_W     = 32;
  localparam logic [LEN_W-1:0] CFG_RESET = 13'd4096;

  // Opcodes carried on the input tuser.
  localparam logic [1:0] OP_DATA = 2'd0;
  localparam logic [1:0] OP_NEW  = 2'd1;
  localparam logic [1:0] OP_EOS  = 2'd2;

  // Queue between the front and the engine.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Output tdata layout.
  localparam int TDATA_W   = 40;
  localparam int BYTE_LSB  = 0;
  localparam int IDX_LSB   = 8;
  localparam int STAT_LSB  = 20;
  localparam int TOTAL_LSB = 23;
  localparam int TPAD_W    = TDATA_W - TOTAL_LSB - LEN_W;
  localparam int USER_HAS  = 0;
  localparam int USER_END  = 1;

  typedef enum logic [1:0] {
    K_DATA,
    K_NEW,
    K_EOS
  } kind_t;

  typedef enum logic [2:0] {
    PH_LEN,
    PH_COUNT,
    PH_FLEN,
    PH_DATA
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK,
    ST_LONG,
    ST_BAD,
    ST_TRUNC,
    ST_END
  } status_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic             has_byte;
    logic [7:0]       data_byte;
    logic [IDX_W-1:0] field_index;
    logic             field_last;
    logic             frame_end;
    status_t          status;
    logic [LEN_W-1:0] field_total;
  } result_t;

endpackage

>>> hdl/ldrd_front.sv
module ldrd_front (
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [7:0]    s_axis_tdata,   // in_byte[7:0]
  input  logic [1:0]    s_axis_tuser,   // opcode[1:0]
  input  logic          q_ready,
  output logic          q_push,
  output ldrd_pkg::item_t q_item
);
  import ldrd_pkg::*;

  logic known;

  // Sort the opcode into a kind; the unused code is taken and dropped here.
  always_comb begin
    known       = 1'b1;
    q_item.data = s_axis_tdata;
    case (s_axis_tuser)
      OP_DATA: q_item.kind = K_DATA;
      OP_NEW:  q_item.kind = K_NEW;
      OP_EOS:  q_item.kind = K_EOS;
      default: begin
        q_item.kind = K_DATA;
        known       = 1'b0;
      end
    endcase
  end

  assign s_axis_tready = q_ready;
  assign q_push        = s_axis_tvalid && q_ready && known;

endmodule

>>> hdl/ldrd_queue.sv
module ldrd_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ldrd_pkg::item_t push_item,
  output logic            ready,
  output logic            valid,
  output ldrd_pkg::item_t pop_item,
  input  logic            pop
);
  import ldrd_pkg::*;

  item_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign ready    = count != QCNT_W'(QUEUE_DEPTH);
  assign valid    = count != '0;
  assign pop_item = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> hdl/ldrd_engine.sv
module ldrd_engine (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [ldrd_pkg::LEN_W-1:0] cfg_max,
  input  logic                      q_valid,
  input  ldrd_pkg::item_t           q_item,
  output logic                      q_pop,
  output logic                      m_valid,
  input  logic                      m_ready,
  output ldrd_pkg::result_t         m_res
);
  import ldrd_pkg::*;

  phase_t           phase, phase_next;
  logic [HDR_W-1:0] hdr_shift, hdr_shift_next;
  logic [1:0]       hdr_cnt, hdr_cnt_next;
  logic [LEN_W-1:0] frame_length, frame_length_next;
  logic [LEN_W-1:0] body_position, body_position_next;
  logic [LEN_W-1:0] fields_remaining, fields_remaining_next;
  logic [LEN_W-1:0] field_bytes_left, field_bytes_left_next;
  logic [LEN_W-1:0] current_field, current_field_next;
  logic             closed, closed_next;

  logic             fire, live_data, live_eos;
  logic [LEN_W-1:0] lim, bp_inc, rem;
  logic [HDR_W-1:0] hdr_word;
  logic             hdr_done, at_end, rem_lt4, last_field, byte_last;
  logic             word_gt_lim, word_lt4, word_zero, word_gt_rem, finish;
  logic             res_valid;
  result_t          res;

  assign fire      = q_valid && (!m_valid || m_ready);
  assign q_pop     = fire;
  assign live_data = fire && !closed && q_item.kind == K_DATA;
  assign live_eos  = fire && !closed && q_item.kind == K_EOS;

  assign lim         = (cfg_max > LEN_W'(MAX_MSG)) ? LEN_W'(MAX_MSG) : cfg_max;
  assign hdr_word    = hdr_shift | ({24'd0, q_item.data} << {hdr_cnt, 3'b000});
  assign hdr_done    = hdr_cnt == 2'd3;
  assign bp_inc      = body_position + 1'b1;
  assign rem         = frame_length - bp_inc;
  assign at_end      = bp_inc == frame_length;
  assign rem_lt4     = rem < LEN_W'(4);
  assign last_field  = fields_remaining == LEN_W'(1);
  assign byte_last   = field_bytes_left == LEN_W'(1);
  assign word_gt_lim = hdr_word > HDR_W'(lim);
  assign word_lt4    = hdr_word < HDR_W'(4);
  assign word_zero   = hdr_word == '0;
  assign word_gt_rem = hdr_word > HDR_W'(rem);

  // A field completes on its last payload byte, or at once for an empty field.
  assign finish = (phase == PH_DATA && byte_last) ||
                  (phase == PH_FLEN && hdr_done && !word_gt_rem && word_zero);

  always_comb begin
    phase_next            = phase;
    hdr_shift_next        = hdr_shift;
    hdr_cnt_next          = hdr_cnt;
    frame_length_next     = frame_length;
    body_position_next    = body_position;
    fields_remaining_next = fields_remaining;
    field_bytes_left_next = field_bytes_left;
    current_field_next    = current_field;
    closed_next           = closed;
    if (fire && q_item.kind == K_NEW) begin
      phase_next            = PH_LEN;
      hdr_shift_next        = '0;
      hdr_cnt_next          = '0;
      frame_length_next     = '0;
      body_position_next    = '0;
      fields_remaining_next = '0;
      field_bytes_left_next = '0;
      current_field_next    = '0;
      closed_next           = 1'b0;
    end else if (live_eos) begin
      closed_next = 1'b1;
    end else if (live_data) begin
      if (phase == PH_DATA) begin
        body_position_next    = bp_inc;
        field_bytes_left_next = field_bytes_left - 1'b1;
      end else if (!hdr_done) begin
        hdr_shift_next = hdr_word;
        hdr_cnt_next   = hdr_cnt + 1'b1;
        if (phase != PH_LEN) begin
          body_position_next = bp_inc;
        end
      end else begin
        hdr_shift_next = '0;
        hdr_cnt_next   = '0;
        case (phase)
          PH_LEN: begin
            if (word_gt_lim || word_lt4) begin
              closed_next = 1'b1;
            end else begin
              frame_length_next  = hdr_word[LEN_W-1:0];
              body_position_next = '0;
              phase_next         = PH_COUNT;
            end
          end
          PH_COUNT: begin
            body_position_next = bp_inc;
            if (word_gt_lim) begin
              closed_next = 1'b1;
            end else begin
              fields_remaining_next = hdr_word[LEN_W-1:0];
              current_field_next    = '0;
              if (word_zero) begin
                if (at_end) begin
                  phase_next         = PH_LEN;
                  body_position_next = '0;
                  frame_length_next  = '0;
                end else begin
                  closed_next = 1'b1;
                end
              end else if (rem_lt4) begin
                closed_next = 1'b1;
              end else begin
                phase_next = PH_FLEN;
              end
            end
          end
          PH_FLEN: begin
            body_position_next = bp_inc;
            if (word_gt_rem) begin
              closed_next = 1'b1;
            end else begin
              field_bytes_left_next = hdr_word[LEN_W-1:0];
              if (!word_zero) begin
                phase_next = PH_DATA;
              end
            end
          end
          default: begin
          end
        endcase
      end
      if (finish) begin
        current_field_next    = current_field + 1'b1;
        fields_remaining_next = fields_remaining - 1'b1;
        if (last_field) begin
          if (at_end) begin
            phase_next         = PH_LEN;
            body_position_next = '0;
            frame_length_next  = '0;
            current_field_next = '0;
          end else begin
            closed_next = 1'b1;
          end
        end else if (rem_lt4) begin
          closed_next = 1'b1;
        end else begin
          phase_next = PH_FLEN;
        end
      end
    end
  end

  always_comb begin
    res_valid       = 1'b0;
    res             = '0;
    res.field_index = current_field[IDX_W-1:0];
    if (live_eos) begin
      res_valid     = 1'b1;
      res.frame_end = 1'b1;
      res.status    = (phase == PH_LEN && hdr_cnt == 2'd0) ? ST_END : ST_TRUNC;
    end else if (live_data) begin
      if (phase == PH_DATA && !byte_last) begin
        res_valid     = 1'b1;
        res.has_byte  = 1'b1;
        res.data_byte = q_item.data;
      end else if (phase != PH_DATA && hdr_done) begin
        case (phase)
          PH_LEN: begin
            if (word_gt_lim || word_lt4) begin
              res_valid     = 1'b1;
              res.frame_end = 1'b1;
              res.status    = word_gt_lim ? ST_LONG : ST_BAD;
            end
          end
          PH_COUNT: begin
            if (word_gt_lim || rem_lt4 || word_zero) begin
              res_valid     = 1'b1;
              res.frame_end = 1'b1;
              res.status    = (!word_gt_lim && word_zero && at_end) ? ST_OK : ST_BAD;
            end
          end
          PH_FLEN: begin
            if (word_gt_rem) begin
              res_valid     = 1'b1;
              res.frame_end = 1'b1;
              res.status    = ST_BAD;
            end
          end
          default: begin
          end
        endcase
      end
      if (finish) begin
        res_valid      = 1'b1;
        res.has_byte   = phase == PH_DATA;
        res.data_byte  = (phase == PH_DATA) ? q_item.data : 8'd0;
        res.field_last = 1'b1;
        res.frame_end  = 1'b0;
        res.status     = ST_OK;
        if (last_field) begin
          res.frame_end = 1'b1;
          if (at_end) begin
            res.field_total = current_field + 1'b1;
          end else begin
            res.status = ST_BAD;
          end
        end else if (rem_lt4) begin
          res.frame_end = 1'b1;
          res.status    = ST_BAD;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_LEN;
      hdr_shift        <= '0;
      hdr_cnt          <= '0;
      frame_length     <= '0;
      body_position    <= '0;
      fields_remaining <= '0;
      field_bytes_left <= '0;
      current_field    <= '0;
      closed           <= 1'b0;
      m_valid          <= 1'b0;
    end else begin
      phase            <= phase_next;
      hdr_shift        <= hdr_shift_next;
      hdr_cnt          <= hdr_cnt_next;
      frame_length     <= frame_length_next;
      body_position    <= body_position_next;
      fields_remaining <= fields_remaining_next;
      field_bytes_left <= field_bytes_left_next;
      current_field    <= current_field_next;
      closed           <= closed_next;
      if (fire && res_valid) begin
        m_valid <= 1'b1;
      end else if (m_ready) begin
        m_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_valid) begin
      m_res <= res;
    end
  end

endmodule

>>> hdl/length_prefixed_request_deframer.sv
// Length-prefixed request deframer.
// The input stream carries one transaction per received byte: tdata holds the
// byte and tuser the opcode (data byte, new connection, end of stream). Each
// frame is a 4-byte little-endian length, then a body made of a 4-byte field
// count and that many fields, each a 4-byte length followed by its payload.
// The output stream gives payload bytes as they arrive, tagged with their field
// index, and marks field completion on tlast; a frame-end flag in tuser comes
// with a status at the end of each frame, on every error and at end of stream.
// After an error or end of stream all input but a new connection is dropped.
// The configuration channel writes the largest accepted frame length and
// field count; the value in use is capped at 4096.
// Throughput is one byte per clock while the receiver takes the output: the
// engine updates its frame state once per byte. A two-entry queue sits between
// the input front and the engine, and the engine drives a one-deep output
// register, so each byte is held first in a queue entry and its result then in
// the output register before m_axis_tvalid rises. When the receiver stalls, the
// engine holds, the queue takes at most two more bytes and s_axis_tready then
// drops. Reset clears the frame state, opens the stream, empties the queue and
// the output register, and restores the limit to 4096.
module length_prefixed_request_deframer (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,  // in_byte[7:0]
  input  logic [1:0]                        s_axis_tuser,  // opcode[1:0]
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // data_byte[7:0], field_index[19:8], status[22:20], field_total[35:23], zero pad
  output logic [ldrd_pkg::TDATA_W-1:0]      m_axis_tdata,
  output logic                              m_axis_tlast,  // field_last
  output logic [1:0]                        m_axis_tuser,  // has_byte[0], frame_end[1]
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ldrd_pkg::LEN_W-1:0]        cfg_data       // max_message_length
);
  import ldrd_pkg::*;

  logic [LEN_W-1:0] max_message_length;
  logic             q_ready, q_push, q_valid, q_pop;
  item_t            push_item, pop_item;
  result_t          m_res;

  // The limit register is always ready; the user must write it only while idle, as the block does not enforce this.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_message_length <= CFG_RESET;
    end else if (cfg_valid) begin
      max_message_length <= cfg_data;
    end
  end

  ldrd_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_ready       (q_ready),
    .q_push        (q_push),
    .q_item        (push_item)
  );

  ldrd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (push_item),
    .ready     (q_ready),
    .valid     (q_valid),
    .pop_item  (pop_item),
    .pop       (q_pop)
  );

  ldrd_engine u_engine (
    .clk     (clk),
    .rst     (rst),
    .cfg_max (max_message_length),
    .q_valid (q_valid),
    .q_item  (pop_item),
    .q_pop   (q_pop),
    .m_valid (m_axis_tvalid),
    .m_ready (m_axis_tready),
    .m_res   (m_res)
  );

  // Pack the result into the stream fields.
  assign m_axis_tdata = {TPAD_W'(0), m_res.field_total, m_res.status,
                         m_res.field_index, m_res.data_byte};
  assign m_axis_tlast = m_res.field_last;
  assign m_axis_tuser = {m_res.frame_end, m_res.has_byte};

endmodule

>>> hdl/ldrd_checker.sv
module ldrd_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [ldrd_pkg::TDATA_W-1:0] m_axis_tdata,
  input logic                         m_axis_tlast,
  input logic [1:0]                   m_axis_tuser
);
  import ldrd_pkg::*;

  logic [7:0]       data_byte;
  logic [2:0]       status;
  logic [LEN_W-1:0] field_total;
  logic             has_byte, frame_end;

  assign data_byte   = m_axis_tdata[BYTE_LSB +: 8];
  assign status      = m_axis_tdata[STAT_LSB +: 3];
  assign field_total = m_axis_tdata[TOTAL_LSB +: LEN_W];
  assign has_byte    = m_axis_tuser[USER_HAS];
  assign frame_end   = m_axis_tuser[USER_END];

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
      $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // Reset leaves no result pending.
  a_reset: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // Without a payload byte the byte field reads zero.
  a_no_byte: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !has_byte |-> data_byte == 8'd0)
    else $error("data byte set without payload");

  // Status and field count only travel with a frame end.
  a_no_end: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !frame_end |-> status == ST_OK && field_total == '0)
    else $error("status set without frame end");

  // Only a good frame reports a field count.
  a_err_total: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && frame_end && status != ST_OK |-> field_total == '0)
    else $error("field count on failed frame");

endmodule

bind length_prefixed_request_deframer ldrd_checker u_ldrd_checker (.*);
